### rtl/apsp_pkg.sv
// Shared constants, types and helpers for the all-pairs shortest path block.
`default_nettype none
package apsp_pkg;

	localparam int MAX_NODES   = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_W      = 7;
	localparam int WEIGHT_W    = 16;
	localparam int DIST_W      = 32;
	localparam int IDX_W       = $clog2(MAX_NODES);
	localparam int DRAIN_CYC   = MAX_NODES + 4;
	localparam int CNT_W       = $clog2(DRAIN_CYC + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST  = 7'd64;
	localparam logic [NODE_W-1:0] SOURCE_NODE_RST = 7'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT  = 1'b0,
		REG_SOURCE_NODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              reach;
		logic [DIST_W-1:0] d;
	} entry_t;

	typedef struct packed {
		logic             v;
		logic [IDX_W-1:0] j;
		entry_t           e;
	} tok_t;

	typedef struct packed {
		logic              clr;
		logic [IDX_W-1:0]  clr_addr;
		logic              rd_all;
		logic              rd_one;
		logic [IDX_W-1:0]  rd_row;
		logic [IDX_W-1:0]  rd_addr;
		logic              lat_dik;
		logic              relax;
		logic [IDX_W-1:0]  k;
		logic [NODE_W-1:0] n;
		logic              wr;
		logic [IDX_W-1:0]  wr_row;
		logic [IDX_W-1:0]  wr_addr;
		entry_t            wr_data;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_FLUSH,
		ST_PRE,
		ST_LAT,
		ST_STREAM,
		ST_DRAIN,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
			input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? '1 : s[DIST_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/apsp_edge_if.sv
// Edge input channel.
`default_nettype none
interface apsp_edge_if import apsp_pkg::*;;
	logic                valid;
	logic                ready;
	logic [NODE_W-1:0]   from_node;
	logic [NODE_W-1:0]   to_node;
	logic [WEIGHT_W-1:0] edge_weight;
	logic                edge_valid;
	logic                last_edge;
	modport source (output valid, from_node, to_node, edge_weight, edge_valid, last_edge,
		input ready);
	modport sink (input valid, from_node, to_node, edge_weight, edge_valid, last_edge,
		output ready);
endinterface
`default_nettype wire

### rtl/apsp_result_if.sv
// Result output channel.
`default_nettype none
interface apsp_result_if import apsp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] target_node;
	logic [DIST_W-1:0] distance;
	logic              unreachable;
	logic              last_result;
	modport source (output valid, target_node, distance, unreachable, last_result,
		input ready);
	modport sink (input valid, target_node, distance, unreachable, last_result,
		output ready);
endinterface
`default_nettype wire

### rtl/apsp_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface apsp_cfg_if import apsp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [NODE_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/apsp_cell.sv
// One matrix row: row memory, held d[i][k] and relaxation of passing row-k tokens.
`default_nettype none
module apsp_cell import apsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_ctl_t  ctl,
	input  wire tok_t       tok_in,
	output tok_t            tok_out,
	output entry_t          rd_data
);

	entry_t           mem_q [MAX_NODES];
	entry_t           rd_q;
	entry_t           dik_q;
	tok_t             tok_s1;
	logic             rd_sel;
	logic [IDX_W-1:0] rd_addr;
	logic             active;
	logic [DIST_W-1:0] cand;
	logic             upd;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;

	always_comb begin
		rd_sel  = ctl.rd_all | (ctl.rd_one & (ctl.rd_row == idx));
		rd_addr = rd_sel ? ctl.rd_addr : tok_in.j;
		// the pivot row never improves during its own pass, so it sits out
		active  = ctl.relax & ({1'b0, idx} < ctl.n) & (idx != ctl.k);
		cand    = sat_add(dik_q.d, tok_s1.e.d);
		upd     = active & tok_s1.v & dik_q.reach & tok_s1.e.reach
			& (!rd_q.reach | (cand < rd_q.d));
		we      = 1'b0;
		waddr   = tok_s1.j;
		wdata   = '{reach: 1'b1, d: cand};
		if (ctl.clr) begin
			we    = 1'b1;
			waddr = ctl.clr_addr;
			wdata = '{reach: (ctl.clr_addr == idx), d: '0};
		end else if (ctl.wr && ctl.wr_row == idx) begin
			we    = 1'b1;
			waddr = ctl.wr_addr;
			wdata = ctl.wr_data;
		end else if (upd) begin
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[rd_addr];
		if (ctl.lat_dik) begin
			dik_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	assign tok_out = tok_s1;
	assign rd_data = rd_q;

endmodule
`default_nettype wire

### rtl/all_pairs_shortest_path.sv
// Top level: edge loading, pivot sequencing, chain of row cells and result output.
`default_nettype none
// Edges are taken one per cycle in the load state into a 64 x 64 distance matrix held as
// one row memory per cell. The item flagged last_edge starts the relaxation: for each pivot
// k the pivot row is read out one entry per cycle and shifted down the chain of 64 row
// cells, each cell updating its own row as the token passes. Results then leave one at a
// time, the next entry read only once the sink has taken the last. After reset, and after
// the last result of each graph, the matrix is cleared in a pass during which no edge is
// taken; configuration writes are taken at any time.
module all_pairs_shortest_path import apsp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	apsp_edge_if.sink   edge_in,
	apsp_result_if.source result_out,
	apsp_cfg_if.sink    cfg
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [NODE_W-1:0] node_count_q, source_node_q;
	logic [NODE_W-1:0] n_w;
	logic              src_ok;
	logic [IDX_W-1:0]  src_row;
	cell_ctl_t         ctl;
	entry_t            cell_rd [MAX_NODES];
	tok_t              tok [MAX_NODES];
	logic              in_ready;
	logic              in_xfer;
	logic              edge_ok;

	logic              src_v_s1;
	logic [IDX_W-1:0]  src_j_s1;
	logic              ld_v_s1;
	logic [IDX_W-1:0]  ld_row_s1, ld_col_s1;
	logic [DIST_W-1:0] ld_w_s1;
	logic              fwd_v_q;
	logic [IDX_W-1:0]  fwd_row_q, fwd_col_q;
	entry_t            fwd_e_q;
	entry_t            cur;
	logic              ld_upd;

	logic              out_v_q;
	logic [NODE_W-1:0] out_target_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_unr_q;
	logic              out_last_q;

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= NODE_COUNT_RST;
			source_node_q <= SOURCE_NODE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_NODE_COUNT:  node_count_q  <= cfg.data;
				REG_SOURCE_NODE: source_node_q <= cfg.data;
			endcase
		end
	end

	always_comb begin
		if (node_count_q == '0) begin
			n_w = NODE_W'(1);
		end else if (node_count_q > NODE_W'(MAX_NODES)) begin
			n_w = NODE_W'(MAX_NODES);
		end else begin
			n_w = node_count_q;
		end
		src_ok  = (source_node_q != '0) && (source_node_q <= n_w);
		src_row = IDX_W'(source_node_q - NODE_W'(1));
	end

	assign in_xfer = edge_in.valid & in_ready;
	assign edge_ok = edge_in.edge_valid
		&& edge_in.from_node != '0 && edge_in.from_node <= NODE_W'(MAX_NODES)
		&& edge_in.to_node != '0 && edge_in.to_node <= NODE_W'(MAX_NODES)
		&& edge_in.from_node != edge_in.to_node;

	// edge merge: read in the accept cycle, compare and write in the cycle after
	always_comb begin
		if (fwd_v_q && fwd_row_q == ld_row_s1 && fwd_col_q == ld_col_s1) begin
			cur = fwd_e_q;
		end else begin
			cur = cell_rd[ld_row_s1];
		end
		ld_upd = ld_v_s1 & (!cur.reach | (ld_w_s1 < cur.d));
	end

	always_ff @(posedge clk) begin
		ld_row_s1 <= IDX_W'(edge_in.from_node - NODE_W'(1));
		ld_col_s1 <= IDX_W'(edge_in.to_node - NODE_W'(1));
		ld_w_s1   <= DIST_W'(edge_in.edge_weight[WEIGHT_BITS-1:0]);
		fwd_row_q <= ld_row_s1;
		fwd_col_q <= ld_col_s1;
		fwd_e_q   <= '{reach: 1'b1, d: ld_w_s1};
		src_j_s1  <= cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1  <= 1'b0;
			fwd_v_q  <= 1'b0;
			src_v_s1 <= 1'b0;
		end else begin
			ld_v_s1  <= in_xfer & edge_ok;
			fwd_v_q  <= ld_upd;
			src_v_s1 <= (state_q == ST_STREAM);
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		k_d      = k_q;
		in_ready = 1'b0;
		ctl          = '0;
		ctl.clr_addr = cnt_q[IDX_W-1:0];
		ctl.k        = k_q;
		ctl.n        = n_w;
		ctl.wr       = ld_upd;
		ctl.wr_row   = ld_row_s1;
		ctl.wr_addr  = ld_col_s1;
		ctl.wr_data  = '{reach: 1'b1, d: ld_w_s1};
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr = 1'b1;
				ctl.wr  = 1'b0;
				cnt_d   = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MAX_NODES - 1)) begin
					cnt_d   = '0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				in_ready    = 1'b1;
				ctl.rd_one  = in_xfer;
				ctl.rd_row  = IDX_W'(edge_in.from_node - NODE_W'(1));
				ctl.rd_addr = IDX_W'(edge_in.to_node - NODE_W'(1));
				if (in_xfer && edge_in.last_edge) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				k_d     = '0;
				state_d = ST_PRE;
			end
			ST_PRE: begin
				ctl.rd_all  = 1'b1;
				ctl.rd_addr = k_q;
				state_d     = ST_LAT;
			end
			ST_LAT: begin
				ctl.lat_dik = 1'b1;
				cnt_d       = '0;
				state_d     = ST_STREAM;
			end
			ST_STREAM: begin
				ctl.relax   = 1'b1;
				ctl.rd_one  = 1'b1;
				ctl.rd_row  = k_q;
				ctl.rd_addr = cnt_q[IDX_W-1:0];
				cnt_d       = cnt_q + CNT_W'(1);
				if (NODE_W'(cnt_q) == n_w - NODE_W'(1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctl.relax = 1'b1;
				cnt_d     = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DRAIN_CYC)) begin
					cnt_d = '0;
					if ({1'b0, k_q} == n_w - NODE_W'(1)) begin
						state_d = ST_OUT_RD;
					end else begin
						k_d     = k_q + IDX_W'(1);
						state_d = ST_PRE;
					end
				end
			end
			ST_OUT_RD: begin
				ctl.rd_one  = 1'b1;
				ctl.rd_row  = src_row;
				ctl.rd_addr = cnt_q[IDX_W-1:0];
				state_d     = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (result_out.ready) begin
					if (out_last_q) begin
						cnt_d   = '0;
						state_d = ST_CLEAR;
					end else begin
						cnt_d   = cnt_q + CNT_W'(1);
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

	// chain of row cells, fed with the pivot row
	assign tok[0] = '{v: src_v_s1, j: src_j_s1, e: cell_rd[k_q]};

	for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
		if (i < MAX_NODES - 1) begin : g_mid
			apsp_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_W'(i)),
				.ctl     (ctl),
				.tok_in  (tok[i]),
				.tok_out (tok[i+1]),
				.rd_data (cell_rd[i])
			);
		end else begin : g_end
			apsp_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_W'(i)),
				.ctl     (ctl),
				.tok_in  (tok[i]),
				.tok_out (),
				.rd_data (cell_rd[i])
			);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			out_target_q <= NODE_W'(cnt_q) + NODE_W'(1);
			out_unr_q    <= !(src_ok && cell_rd[src_row].reach);
			out_dist_q   <= (src_ok && cell_rd[src_row].reach) ? cell_rd[src_row].d : '0;
			out_last_q   <= (NODE_W'(cnt_q) == n_w - NODE_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_OUT_LD) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign edge_in.ready          = in_ready;
	assign result_out.valid       = out_v_q;
	assign result_out.target_node = out_target_q;
	assign result_out.distance    = out_dist_q;
	assign result_out.unreachable = out_unr_q;
	assign result_out.last_result = out_last_q;

endmodule
`default_nettype wire

### rtl/apsp_checker.sv
// Port-level checks for the shortest path block, bound to the top level.
`default_nettype none
module apsp_checker import apsp_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [NODE_W-1:0] out_target,
	input wire logic [DIST_W-1:0] out_dist,
	input wire logic              out_unr,
	input wire logic              out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_target) && $stable(out_dist))
		else $error("result changed while stalled");

	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(in_valid && in_ready))
		else $error("edge transfer while results pending");

	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("input reopened before final result");

	a_unr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_unr |-> out_dist == '0)
		else $error("unreachable result with non-zero distance");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_target != '0 && out_target <= NODE_W'(MAX_NODES))
		else $error("target node out of range");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (edge_in.valid),
	.in_ready   (edge_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_target (result_out.target_node),
	.out_dist   (result_out.distance),
	.out_unr    (result_out.unreachable),
	.out_last   (result_out.last_result)
);
`default_nettype wire

### tb/all_pairs_shortest_path_test.sv
// Testbench for all_pairs_shortest_path: loads directed and random graphs, checks each result.
`default_nettype none
module all_pairs_shortest_path_test;
	import apsp_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] path_len;
		logic              unreach;
		logic              last;
	} path_result_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;          // no idling on either side while set
	int   mismatches;

	apsp_edge_if   edge_ch();
	apsp_result_if result_ch();
	apsp_cfg_if    cfg_ch();

	all_pairs_shortest_path i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_in   (edge_ch),
		.result_out(result_ch),
		.cfg       (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the graph and the registers
	logic [DIST_W-1:0] shadow_dist [MAX_NODES*MAX_NODES];
	bit                shadow_reach [MAX_NODES*MAX_NODES];
	logic [NODE_W-1:0] shadow_count;
	logic [NODE_W-1:0] shadow_source;
	path_result_t      pending_paths[$];

	function automatic void clear_shadow_graph();
		for (int i = 0; i < MAX_NODES*MAX_NODES; i++) begin
			shadow_dist[i]  = '0;
			shadow_reach[i] = 1'b0;
		end
		for (int i = 0; i < MAX_NODES; i++)
			shadow_reach[i*MAX_NODES+i] = 1'b1;
	endfunction

	function automatic logic [DIST_W-1:0] add_saturated(logic [DIST_W-1:0] a,
			logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

	// Store the edge; on the final item relax all pairs and queue the source row
	function automatic void predict_paths(logic [NODE_W-1:0] from_n, logic [NODE_W-1:0] to_n,
			logic [WEIGHT_W-1:0] w, logic ev, logic last);
		int n, slot, ik, kj, ij;
		logic [DIST_W-1:0] cand;
		path_result_t res;
		if (ev && from_n >= 1 && from_n <= MAX_NODES && to_n >= 1 && to_n <= MAX_NODES
				&& from_n != to_n) begin
			slot = (from_n - 1) * MAX_NODES + (to_n - 1);
			if (!shadow_reach[slot] || DIST_W'(w) < shadow_dist[slot]) begin
				shadow_dist[slot]  = DIST_W'(w);
				shadow_reach[slot] = 1'b1;
			end
		end
		if (!last)
			return;
		n = shadow_count < 1 ? 1 : (shadow_count > MAX_NODES ? MAX_NODES : int'(shadow_count));
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++) begin
				ik = i * MAX_NODES + k;
				if (!shadow_reach[ik])
					continue;
				for (int j = 0; j < n; j++) begin
					kj = k * MAX_NODES + j;
					ij = i * MAX_NODES + j;
					if (!shadow_reach[kj])
						continue;
					cand = add_saturated(shadow_dist[ik], shadow_dist[kj]);
					if (!shadow_reach[ij] || cand < shadow_dist[ij]) begin
						shadow_dist[ij]  = cand;
						shadow_reach[ij] = 1'b1;
					end
				end
			end
		for (int t = 0; t < n; t++) begin
			res = '0;
			res.node = NODE_W'(t + 1);
			res.unreach = 1'b1;
			if (shadow_source >= 1 && shadow_source <= n) begin
				slot = (int'(shadow_source) - 1) * MAX_NODES + t;
				res.unreach = !shadow_reach[slot];
				res.path_len = shadow_reach[slot] ? shadow_dist[slot] : '0;
			end
			res.last = (t + 1 == n);
			pending_paths = {pending_paths, res};
		end
		clear_shadow_graph();
	endfunction

	// Result side: random back-pressure and comparison against the oldest expectation
	always @(posedge clk) begin
		path_result_t got, want;
		result_ch.ready <= steady || ($urandom_range(99) >= 11);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = {result_ch.target_node, result_ch.distance, result_ch.unreachable,
				result_ch.last_result};
			if (pending_paths.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: node %0d dist %0d unreach %0b last %0b",
						got.node, got.path_len, got.unreach, got.last);
			end else begin
				want = pending_paths.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected node %0d dist %0d unreach %0b ",
							"last %0b, got node %0d dist %0d unreach %0b last %0b"},
							want.node, want.path_len, want.unreach, want.last,
							got.node, got.path_len, got.unreach, got.last);
				end
			end
		end
	end

	task automatic send_edge(int from_n, int to_n, int w, bit ev, bit last);
		while (!steady && $urandom_range(99) < 11) begin
			edge_ch.valid <= 1'b0;
			@(posedge clk);
		end
		edge_ch.valid       <= 1'b1;
		edge_ch.from_node   <= NODE_W'(from_n);
		edge_ch.to_node     <= NODE_W'(to_n);
		edge_ch.edge_weight <= WEIGHT_W'(w);
		edge_ch.edge_valid  <= ev;
		edge_ch.last_edge   <= last;
		do @(posedge clk); while (!edge_ch.ready);
		predict_paths(NODE_W'(from_n), NODE_W'(to_n), WEIGHT_W'(w), ev, last);
	endtask

	// Drop valid after the last transfer and wait for every pending result
	task automatic await_results();
		edge_ch.valid <= 1'b0;
		while (pending_paths.size() != 0)
			@(posedge clk);
	endtask

	// Both registers back to back, valid held high across the pair
	task automatic write_config(int count, int source);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_NODE_COUNT;
		cfg_ch.data  <= NODE_W'(count);
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_count = NODE_W'(count);
		cfg_ch.index <= REG_SOURCE_NODE;
		cfg_ch.data  <= NODE_W'(source);
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_source = NODE_W'(source);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_directed_edges();
		write_config(4, 1);
		send_edge(1, 2, 65535, 1, 0);
		send_edge(1, 2, 7, 1, 0);        // smaller weight replaces
		send_edge(1, 2, 9, 1, 0);        // larger weight ignored
		send_edge(2, 3, 0, 1, 0);
		send_edge(3, 3, 5, 1, 0);        // self loop
		send_edge(0, 4, 1, 1, 0);        // out-of-range tail
		send_edge(4, 127, 1, 1, 0);      // out-of-range head
		send_edge(3, 64, 2, 1, 0);       // stored, above n
		send_edge(2, 4, 3, 0, 0);        // no edge carried
		send_edge(3, 1, 65535, 1, 1);
		await_results();
	endtask

	task automatic test_register_extremes();
		write_config(1, 1);
		send_edge(1, 1, 0, 0, 1);        // empty graph, single node
		await_results();
		write_config(0, 1);              // clamps to one node
		send_edge(1, 2, 4, 1, 1);
		await_results();
		write_config(3, 0);              // source below range
		send_edge(1, 2, 4, 1, 0);
		send_edge(2, 3, 4, 1, 1);
		await_results();
		write_config(3, 5);              // source above n
		send_edge(1, 2, 4, 1, 1);
		await_results();
		write_config(127, 64);           // clamps to 64 nodes
		for (int i = 1; i < 64; i++)
			send_edge(i + 1, i, 65535 - i, 1, 0);
		send_edge(1, 64, 65535, 1, 1);
		await_results();
	endtask

	task automatic random_graph(int n, int edges, bit full);
		int src, f, t;
		src = $urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(n, 1);
		write_config(full ? ($urandom_range(1) ? 64 : 127) : n, src);
		for (int e = 0; e < edges; e++) begin
			if ($urandom_range(9) == 0) begin
				f = $urandom_range(127);
				t = $urandom_range(127);
			end else begin
				f = $urandom_range(n, 1);
				t = $urandom_range(n, 1);
			end
			send_edge(f, t, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(20),
				$urandom_range(9) != 0, e == edges - 1);
		end
		await_results();
	endtask

	task automatic test_random_graphs();
		for (int g = 0; g < 14; g++) begin
			steady = (g >= 8 && g < 12);
			random_graph($urandom_range(8, 2), $urandom_range(12, 4), 1'b0);
		end
		steady = 1'b0;
		random_graph(64, 20, 1'b1);
	endtask

	initial begin
		mismatches = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		edge_ch.valid <= 1'b0;
		edge_ch.from_node <= '0;
		edge_ch.to_node <= '0;
		edge_ch.edge_weight <= '0;
		edge_ch.edge_valid <= 1'b0;
		edge_ch.last_edge <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_NODE_COUNT;
		cfg_ch.data <= '0;
		shadow_count = NODE_COUNT_RST;
		shadow_source = SOURCE_NODE_RST;
		clear_shadow_graph();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_register_extremes();
		test_random_graphs();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_paths.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### all_pairs_shortest_path.f
rtl/apsp_pkg.sv
rtl/apsp_edge_if.sv
rtl/apsp_result_if.sv
rtl/apsp_cfg_if.sv
rtl/apsp_cell.sv
rtl/all_pairs_shortest_path.sv
rtl/apsp_checker.sv
tb/all_pairs_shortest_path_test.sv
